FILE: rtl/hcbd_pkg.sv
// Shared constants, types and helpers for the chunked body decoder.
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_SIZE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_EXT      = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SIZE_LF  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DATA     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_CR  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_DATA_LF  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_FINAL_CR = 4'd6;
    localparam logic [PHASE_W-1:0] PH_FINAL_LF = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DONE     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ERROR    = 4'd9;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SIZE  = 2'd1;
    localparam logic [1:0] ERR_TERM  = 2'd2;
    localparam logic [1:0] ERR_FINAL = 2'd3;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic [1:0] error_kind;
    } t_result;

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

endpackage

FILE: rtl/hcbd_if.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       new_body;

    modport source (output valid, output in_byte, output new_body, input ready);
    modport sink   (input valid, input in_byte, input new_body, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic [1:0] error_kind;

    modport source (output valid, output payload_valid, output payload_byte,
                    output status, output error_kind, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input status, input error_kind, output ready);
endinterface

FILE: rtl/hcbd_fsm.sv
// Chunk framing state machine: one byte step per enabled cycle.
module hcbd_fsm
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_new_body,
    output t_result    o_result
);

    localparam int DIGIT_LIMIT = SIZE_BITS / 4;
    localparam int DC_W        = $clog2(DIGIT_LIMIT + 1);

    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [DC_W-1:0]      r_digit_count, n_digit_count;
    logic [1:0]           r_err, n_err;

    logic [PHASE_W-1:0]   w_phase;
    logic [SIZE_BITS-1:0] w_bytes;
    logic [DC_W-1:0]      w_dc;
    logic [1:0]           w_err;
    logic [4:0]           w_hex;
    logic [SIZE_BITS-1:0] w_dec;
    logic                 w_pvalid;

    always_comb begin
        // A new body restarts the decoder before this byte is looked at.
        w_phase = i_new_body ? PH_SIZE : r_phase;
        w_bytes = i_new_body ? '0 : r_bytes_left;
        w_dc    = i_new_body ? '0 : r_digit_count;
        w_err   = i_new_body ? ERR_NONE : r_err;
        w_hex   = hex_decode(i_byte);
        w_dec   = w_bytes - {{(SIZE_BITS-1){1'b0}}, 1'b1};

        n_phase       = w_phase;
        n_bytes_left  = w_bytes;
        n_digit_count = w_dc;
        n_err         = w_err;
        w_pvalid      = 1'b0;

        case (w_phase)
            PH_SIZE: begin
                if (w_hex[4]) begin
                    if (w_dc >= DC_W'(DIGIT_LIMIT)) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_SIZE;
                    end else begin
                        n_bytes_left  = {w_bytes[SIZE_BITS-5:0], w_hex[3:0]};
                        n_digit_count = w_dc + DC_W'(1);
                    end
                end else if (w_dc == '0) begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_SIZE;
                end else if (i_byte == CH_SEMI) begin
                    n_phase = PH_EXT;
                end else if (i_byte == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end else begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_SIZE;
                end
            end
            PH_EXT: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end
            end
            PH_SIZE_LF: begin
                n_digit_count = '0;
                if (i_byte != CH_LF) begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_SIZE;
                end else if (w_bytes == '0) begin
                    n_phase = PH_FINAL_CR;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                w_pvalid     = 1'b1;
                n_bytes_left = w_dec;
                if (w_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_DATA_LF;
                end else begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_TERM;
                end
            end
            PH_DATA_LF: begin
                if (i_byte == CH_LF) begin
                    n_phase       = PH_SIZE;
                    n_digit_count = '0;
                    n_bytes_left  = '0;
                end else begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_TERM;
                end
            end
            PH_FINAL_CR: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_FINAL_LF;
                end else begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_FINAL;
                end
            end
            PH_FINAL_LF: begin
                if (i_byte == CH_LF) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_FINAL;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        o_result.payload_valid = w_pvalid;
        o_result.payload_byte  = w_pvalid ? i_byte : 8'd0;
        if (n_phase == PH_DONE) begin
            o_result.status     = ST_DONE;
            o_result.error_kind = ERR_NONE;
        end else if (n_phase == PH_ERROR) begin
            o_result.status     = ST_ERROR;
            o_result.error_kind = n_err;
        end else begin
            o_result.status     = ST_RUN;
            o_result.error_kind = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SIZE;
            r_bytes_left  <= '0;
            r_digit_count <= '0;
            r_err         <= ERR_NONE;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bytes_left  <= n_bytes_left;
            r_digit_count <= n_digit_count;
            r_err         <= n_err;
        end
    end

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_count <= DC_W'(DIGIT_LIMIT))
        else $error("size digit count beyond limit");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_ERROR)
        else $error("phase register left its code range");

    a_err_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ERR_NONE |-> r_phase == PH_ERROR)
        else $error("latched error outside the error phase");

endmodule

FILE: rtl/http_chunked_body_decoder_core.sv
// Top level of the HTTP/1.1 chunked transfer body decoder.
//
// Usage:
//   i_in_ch  - one beat per raw body byte (in_byte) with new_body, which
//              restarts the decoder ahead of that byte.
//   o_out_ch - one result beat for every input beat: payload_valid and
//              payload_byte for decoded payload, status (running, complete,
//              error) and error_kind.
//   Path: a taken beat waits in the input register, moves into the result
//   register when that is free or draining, and its result is offered there.
//   Throughput: one beat per cycle while o_out_ch takes results; the framing
//   state update is combinational logic between the input and result registers.
//   Stall: while o_out_ch is held off the input register keeps one more
//   beat, after which i_in_ch.ready drops; nothing is lost or repeated.
//   Reset (synchronous, active low): both registers empty, decoder expects
//   a chunk-size line. After completion or an error the status repeats for
//   every byte until a beat arrives with new_body set.
module http_chunked_body_decoder_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcbd_in_if.sink           i_in_ch,
    hcbd_out_if.source        o_out_ch
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new_body;

    // Result register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_advance;
    t_result    w_result;

    // Advance the held beat whenever the result register is free or draining.
    assign w_advance     = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_byte     <= i_in_ch.in_byte;
            r_in_new_body <= i_in_ch.new_body;
        end
    end

    hcbd_fsm #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_byte     (r_in_byte),
        .i_new_body (r_in_new_body),
        .o_result   (w_result)
    );

    // Load a fresh result on advance, drop it once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.payload_valid = r_out.payload_valid;
    assign o_out_ch.payload_byte  = r_out.payload_byte;
    assign o_out_ch.status        = r_out.status;
    assign o_out_ch.error_kind    = r_out.error_kind;

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid)
        else $error("held input beat lost while stalled");

    a_payload_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.payload_valid |-> r_out.status == ST_RUN)
        else $error("payload beat with a final status");

    a_kind_with_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error_kind != ERR_NONE |-> r_out.status == ST_ERROR)
        else $error("error kind reported without error status");

endmodule

FILE: bench/http_chunked_body_decoder_core_test.sv
// Self-checking bench for the chunked body decoder: byte stream in, one result beat per byte.
module http_chunked_body_decoder_core_test;
    import hcbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIZE_BITS      = SIZE_BITS_DEF;
    localparam int MAX_DIGITS     = SIZE_BITS / 4;
    localparam int RANDOM_BEATS   = 1950;
    localparam int OPENING_BEATS  = 27;
    localparam int DRAIN_CYCLES   = 8;     // result register plus a little slack
    localparam int LONG_HOLD      = 150;   // receiver hold-off that fills the block
    localparam int HOLD_AT_CYCLE  = 1200;
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat moving on either side

    // One input beat, with an optional hand-written expectation.
    typedef struct packed {
        logic [7:0] b;
        logic       nb;
        logic       fixed;
        t_result    want;
    } t_beat;

    localparam t_result NO_WANT    = '0;
    localparam t_result WANT_DONE  = '{1'b0, 8'h00, ST_DONE, ERR_NONE};
    localparam t_result WANT_SIZE  = '{1'b0, 8'h00, ST_ERROR, ERR_SIZE};
    localparam t_result WANT_TERM  = '{1'b0, 8'h00, ST_ERROR, ERR_TERM};
    localparam t_result WANT_FINAL = '{1'b0, 8'h00, ST_ERROR, ERR_FINAL};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    http_chunked_body_decoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Framing predictor: its own copy of the decoder state.
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]   dec_phase  = PH_SIZE;
    logic [SIZE_BITS-1:0] dec_left   = '0;
    logic [3:0]           dec_digits = '0;
    logic [1:0]           dec_err    = ERR_NONE;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void trip(input logic [1:0] kind);
        dec_phase = PH_ERROR;
        dec_err   = kind;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] c, input logic restart);
        t_result r;
        int      nib;
        r   = '0;
        nib = hex_nibble(c);
        // new_body wipes the framing state before this byte is looked at
        if (restart) begin
            dec_phase  = PH_SIZE;
            dec_left   = '0;
            dec_digits = '0;
            dec_err    = ERR_NONE;
        end
        case (dec_phase)
            PH_SIZE: begin
                if (nib >= 0) begin
                    // one digit too many overflows the size register
                    if (dec_digits >= MAX_DIGITS) begin
                        trip(ERR_SIZE);
                    end else begin
                        dec_left   = {dec_left[SIZE_BITS-5:0], 4'(nib)};
                        dec_digits = dec_digits + 4'd1;
                    end
                end else if (dec_digits == 0) begin
                    trip(ERR_SIZE);
                end else if (c == CH_SEMI) begin
                    dec_phase = PH_EXT;
                end else if (c == CH_CR) begin
                    dec_phase = PH_SIZE_LF;
                end else begin
                    trip(ERR_SIZE);
                end
            end
            PH_EXT: begin
                if (c == CH_CR) dec_phase = PH_SIZE_LF;
            end
            PH_SIZE_LF: begin
                if (c != CH_LF) trip(ERR_SIZE);
                else dec_phase = (dec_left == 0) ? PH_FINAL_CR : PH_DATA;
                dec_digits = '0;
            end
            PH_DATA: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = c;
                dec_left        = dec_left - SIZE_BITS'(1);
                if (dec_left == 0) dec_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (c == CH_CR) dec_phase = PH_DATA_LF;
                else trip(ERR_TERM);
            end
            PH_DATA_LF: begin
                if (c == CH_LF) begin
                    dec_phase  = PH_SIZE;
                    dec_digits = '0;
                    dec_left   = '0;
                end else begin
                    trip(ERR_TERM);
                end
            end
            PH_FINAL_CR: begin
                if (c == CH_CR) dec_phase = PH_FINAL_LF;
                else trip(ERR_FINAL);
            end
            PH_FINAL_LF: begin
                if (c == CH_LF) dec_phase = PH_DONE;
                else trip(ERR_FINAL);
            end
            PH_DONE: begin
            end
            default: dec_phase = PH_ERROR;
        endcase

        if (dec_phase == PH_DONE) begin
            r.status = ST_DONE;
        end else if (dec_phase == PH_ERROR) begin
            r.status     = ST_ERROR;
            r.error_kind = dec_err;
        end else begin
            r.status = ST_RUN;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: opening table, then random bodies and noise.
    // ------------------------------------------------------------------
    t_beat   opening [0:OPENING_BEATS-1];
    t_beat   body_beats [$];
    t_result results_due [$];
    int      next_beat = 0;
    int      mismatches = 0;

    task automatic add_beat(input logic [7:0] b, input logic nb);
        t_beat x;
        x.b     = b;
        x.nb    = nb;
        x.fixed = 1'b0;
        x.want  = NO_WANT;
        body_beats = {body_beats, x};
    endtask

    // Size line: ndig digits (leading zeros pad), mixed case, optional extension.
    task automatic add_size_line(input logic [SIZE_BITS-1:0] size, input int ndig,
                                 input bit with_ext);
        logic [3:0] nib;
        logic [7:0] c;
        for (int i = ndig - 1; i >= 0; i--) begin
            nib = (i < MAX_DIGITS) ? size[4*i +: 4] : 4'h0;
            if (nib < 10) c = 8'h30 + 8'(nib);
            else if ($urandom_range(0, 1) == 1) c = 8'h37 + 8'(nib);
            else c = 8'h57 + 8'(nib);
            add_beat(c, 1'b0);
        end
        if (with_ext) begin
            add_beat(CH_SEMI, 1'b0);
            // extension content is skipped, so anything but CR goes
            repeat ($urandom_range(0, 5)) begin
                c = 8'($urandom_range(0, 255));
                add_beat((c == CH_CR) ? CH_LF : c, 1'b0);
            end
        end
        add_beat(CH_CR, 1'b0);
        add_beat(CH_LF, 1'b0);
    endtask

    // A whole chunked body; a broken one gets a corrupt byte, may be cut
    // short, may carry an over-long size or abandon a huge chunk.
    task automatic add_body(input bit broken);
        int                   first;
        int                   nchunks;
        int                   sel;
        int                   need;
        int                   ndig;
        int                   pos;
        int                   cut;
        bit                   abandoned;
        logic [SIZE_BITS-1:0] size;
        first     = body_beats.size();
        nchunks   = $urandom_range(0, 4);
        abandoned = 1'b0;
        for (int k = 0; k < nchunks; k++) begin
            sel = $urandom_range(0, 15);
            if (sel == 0) size = $urandom_range(13, 64);
            else if (sel == 1 && broken) size = $urandom;
            else size = $urandom_range(1, 12);
            need = 1;
            while (need < MAX_DIGITS && (size >> (4 * need)) != 0) need++;
            ndig = need;
            if ($urandom_range(0, 3) == 0) ndig = $urandom_range(need, MAX_DIGITS);
            if (broken && $urandom_range(0, 7) == 0)
                ndig = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
            add_size_line(size, ndig, $urandom_range(0, 2) == 0);
            if (size > 64) begin
                repeat ($urandom_range(0, 6)) add_beat(8'($urandom_range(0, 255)), 1'b0);
                abandoned = 1'b1;
                break;
            end
            repeat (size) add_beat(8'($urandom_range(0, 255)), 1'b0);
            add_beat(CH_CR, 1'b0);
            add_beat(CH_LF, 1'b0);
        end
        if (!abandoned) begin
            add_size_line('0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_DIGITS) : 1,
                          $urandom_range(0, 2) == 0);
            add_beat(CH_CR, 1'b0);
            add_beat(CH_LF, 1'b0);
        end
        body_beats[first].nb = 1'b1;
        if (broken) begin
            pos = $urandom_range(first, body_beats.size() - 1);
            body_beats[pos].b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
                cut = pos + 1 + $urandom_range(0, 4);
                while (body_beats.size() > cut) void'(body_beats.pop_back());
            end
        end
        // trailing bytes follow the body; on a finished or failed body they are ignored
        repeat ($urandom_range(0, 2)) add_beat(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            add_beat(8'($urandom_range(0, 255)),
                     (i == 0) ? 1'b1 : ($urandom_range(0, 7) == 0));
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of beats with random gaps in between.
    // ------------------------------------------------------------------
    int      send_gap   = 0;
    int      send_burst = 1;
    bit      send_busy;
    t_beat   cur_beat;
    t_result predicted;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.in_byte  <= 8'h00;
            in_ch.new_body <= 1'b0;
        end else begin
            send_busy = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                // advance the predictor on every accepted beat, typed rows included
                cur_beat    = body_beats[next_beat];
                predicted   = decode_byte(cur_beat.b, cur_beat.nb);
                results_due = {results_due, cur_beat.fixed ? cur_beat.want : predicted};
                next_beat++;
                send_busy = 1'b0;
            end
            // hold the offered beat until it is taken
            if (!send_busy) begin
                if (send_gap > 0 || next_beat >= body_beats.size()) begin
                    if (send_gap > 0) send_gap--;
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid    <= 1'b1;
                    in_ch.in_byte  <= body_beats[next_beat].b;
                    in_ch.new_body <= body_beats[next_beat].nb;
                    if (send_burst > 1) begin
                        send_burst--;
                    end else begin
                        send_burst = $urandom_range(1, 40);
                        send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off.
    // ------------------------------------------------------------------
    int rx_cycles  = 0;
    int hold_left  = 0;
    bit held       = 1'b0;
    int stall_left = 0;
    int run_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!held && rx_cycles >= HOLD_AT_CYCLE) begin
                // hold off long enough for the block to back up into its input
                held      = 1'b1;
                hold_left = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                    run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: oldest expectation against each accepted result beat.
    // ------------------------------------------------------------------
    t_result due;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end else begin
                due = results_due.pop_front();
                if (out_ch.payload_valid !== due.payload_valid) begin
                    $error("payload_valid: expected %0d, got %0d",
                           due.payload_valid, out_ch.payload_valid);
                    mismatches++;
                end
                if (out_ch.payload_byte !== due.payload_byte) begin
                    $error("payload_byte: expected %02h, got %02h",
                           due.payload_byte, out_ch.payload_byte);
                    mismatches++;
                end
                if (out_ch.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, out_ch.status);
                    mismatches++;
                end
                if (out_ch.error_kind !== due.error_kind) begin
                    $error("error_kind: expected %0d, got %0d",
                           due.error_kind, out_ch.error_kind);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        // Opening rows: byte, new_body, typed?, expected result.
        opening = '{
            // well-formed body: size 1 with an extension, payload FF, last chunk
            '{"1",     1'b1, 1'b0, NO_WANT},
            '{CH_SEMI, 1'b0, 1'b0, NO_WANT},
            '{8'h00,   1'b0, 1'b0, NO_WANT},                          // skipped
            '{CH_CR,   1'b0, 1'b0, NO_WANT},
            '{CH_LF,   1'b0, 1'b0, NO_WANT},
            '{8'hFF,   1'b0, 1'b1, '{1'b1, 8'hFF, ST_RUN, ERR_NONE}},
            '{CH_CR,   1'b0, 1'b0, NO_WANT},
            '{CH_LF,   1'b0, 1'b0, NO_WANT},
            '{"0",     1'b0, 1'b0, NO_WANT},
            '{CH_CR,   1'b0, 1'b0, NO_WANT},
            '{CH_LF,   1'b0, 1'b0, NO_WANT},
            '{CH_CR,   1'b0, 1'b0, NO_WANT},
            '{CH_LF,   1'b0, 1'b1, WANT_DONE},
            // ignored once the body is complete
            '{8'h00,   1'b0, 1'b1, WANT_DONE},
            // empty size
            '{CH_SEMI, 1'b1, 1'b1, WANT_SIZE},
            // size line CR not followed by LF
            '{"A",     1'b1, 1'b0, NO_WANT},
            '{CH_CR,   1'b0, 1'b0, NO_WANT},
            '{"x",     1'b0, 1'b1, WANT_SIZE},
            // payload not followed by CR
            '{"1",     1'b1, 1'b0, NO_WANT},
            '{CH_CR,   1'b0, 1'b0, NO_WANT},
            '{CH_LF,   1'b0, 1'b0, NO_WANT},
            '{"a",     1'b0, 1'b1, '{1'b1, 8'h61, ST_RUN, ERR_NONE}},
            '{"x",     1'b0, 1'b1, WANT_TERM},
            // last chunk not followed by an empty line
            '{"0",     1'b1, 1'b0, NO_WANT},
            '{CH_CR,   1'b0, 1'b0, NO_WANT},
            '{CH_LF,   1'b0, 1'b0, NO_WANT},
            '{CH_LF,   1'b0, 1'b1, WANT_FINAL}
        };
        for (int i = 0; i < OPENING_BEATS; i++) body_beats = {body_beats, opening[i]};

        // Mostly well-formed bodies with random content, the rest broken or noise.
        while (body_beats.size() < OPENING_BEATS + RANDOM_BEATS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: add_body(1'b0);
                6, 7, 8:          add_body(1'b1);
                default:          add_noise();
            endcase
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (next_beat < body_beats.size()) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/hcbd_pkg.sv
rtl/hcbd_if.sv
rtl/hcbd_fsm.sv
rtl/http_chunked_body_decoder_core.sv
bench/http_chunked_body_decoder_core_test.sv
